[sv/sbm_pkg.sv]
// ----------------------------------------------------------------------------
// sbm_pkg: shared constants and types for the sorted block merge unit
// widths, the front-to-back command record and the order key function
// ----------------------------------------------------------------------------
package sbm_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int AW = $clog2(MAX_ITEMS);
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int IDXW = 10;
    localparam int QDEPTH = 4;
    localparam int QAW = $clog2(QDEPTH);

    // operation codes carried from front to back
    typedef enum logic [1:0]
    {
        OP_LOAD  = 2'd0,
        OP_FETCH = 2'd1,
        OP_NOP   = 2'd2
    } op_t;

    typedef struct packed
    {
        op_t         op;
        logic [63:0] value;
        logic        close;
        logic        fin;
    } cmd_t;

    // order preserving unsigned key, negative zero folded onto positive zero
    function automatic logic [63:0] order_key(input logic [63:0] bits);
        logic [63:0] b;
        b = (bits == 64'h8000_0000_0000_0000) ? 64'd0 : bits;
        if (b[63])
            return ~b;
        return b | 64'h8000_0000_0000_0000;
    endfunction

endpackage

[sv/sbm_front.sv]
// ----------------------------------------------------------------------------
// sbm_front: input acceptance and command queue
// decodes each input item into a command record and buffers it
// ----------------------------------------------------------------------------
module sbm_front
    import sbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        command,
    input  logic [63:0] value_bits,
    input  logic        block_end,
    input  logic        final_item,
    output logic        q_valid,
    input  logic        q_pop,
    output cmd_t        q_cmd
);

    cmd_t           mem_reg [QDEPTH];
    logic [QAW-1:0] wp_reg;
    logic [QAW-1:0] rp_reg;
    logic [QAW:0]   cnt_reg;
    cmd_t           enc;
    logic           push;
    logic           pop;

    // classify the incoming item
    always_comb
    begin
        enc.op    = command ? OP_FETCH : OP_LOAD;
        enc.value = value_bits;
        enc.close = block_end | final_item;
        enc.fin   = final_item;
    end

    assign in_ready = (cnt_reg != (QAW+1)'(QDEPTH));
    assign push     = in_valid & in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign pop      = q_pop & q_valid;
    assign q_cmd    = mem_reg[rp_reg];

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= enc;
    end

    // queue pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
                wp_reg <= wp_reg + 1'b1;
            if (pop)
                rp_reg <= rp_reg + 1'b1;
            cnt_reg <= cnt_reg + (QAW+1)'(push) - (QAW+1)'(pop);
        end
    end

endmodule

[sv/sbm_back.sv]
// ----------------------------------------------------------------------------
// sbm_back: load, merge and fetch engine
// holds two ping-pong buffers and merges each closed block into the run
// ----------------------------------------------------------------------------
module sbm_back
    import sbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_valid,
    output logic        q_pop,
    input  cmd_t        q_cmd,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [63:0] sorted_bits,
    output logic [IDXW-1:0] original_index,
    output logic        last_result,
    output logic        nothing_ready,
    output logic        overflowed
);

    typedef enum logic [6:0]
    {
        S_IDLE  = 7'b0000001,
        S_RDP   = 7'b0000010,
        S_RDQ   = 7'b0000100,
        S_CMP   = 7'b0001000,
        S_FRD   = 7'b0010000,
        S_FOUT  = 7'b0100000,
        S_WAIT  = 7'b1000000
    } state_t;

    // buffers: value and index, two banks each
    logic [63:0]     val_mem0 [MAX_ITEMS];
    logic [63:0]     val_mem1 [MAX_ITEMS];
    logic [IDXW-1:0] idx_mem0 [MAX_ITEMS];
    logic [IDXW-1:0] idx_mem1 [MAX_ITEMS];

    state_t          state_reg;
    logic [CW-1:0]   loaded_reg;
    logic [CW-1:0]   merged_reg;
    logic            cur_reg;
    logic [CW-1:0]   rdp_reg;
    logic            ovf_reg;
    logic            done_reg;
    logic            fin_reg;
    logic [CW-1:0]   p_reg;
    logic [CW-1:0]   q_reg;
    logic [CW-1:0]   k_reg;
    logic [63:0]     pv_reg;
    logic [IDXW-1:0] pi_reg;
    logic [63:0]     qv_reg;
    logic [IDXW-1:0] qi_reg;

    // output item register
    logic            out_valid_reg;
    logic [63:0]     sorted_bits_reg;
    logic [IDXW-1:0] original_index_reg;
    logic            last_result_reg;
    logic            nothing_ready_reg;
    logic            overflowed_reg;

    // read port data per bank
    logic [63:0]     rv0_reg, rv1_reg;
    logic [IDXW-1:0] ri0_reg, ri1_reg;
    logic [AW-1:0]   raddr;
    logic            rd_en;
    logic            rd_bank;

    // write port control
    logic            we;
    logic            wbank;
    logic [AW-1:0]   waddr;
    logic [63:0]     wval;
    logic [IDXW-1:0] widx;

    logic            take_run;
    logic            p_left, q_left;
    logic [63:0]     rv;
    logic [IDXW-1:0] ri;

    assign rv = rd_bank ? rv1_reg : rv0_reg;
    assign ri = rd_bank ? ri1_reg : ri0_reg;
    assign p_left = (p_reg < merged_reg);
    assign q_left = (q_reg < loaded_reg);
    assign take_run = !q_left ? 1'b1 :
                      (!p_left ? 1'b0 : (order_key(pv_reg) <= order_key(qv_reg)));

    logic rb_reg;
    assign rd_bank = rb_reg;

    assign out_valid      = out_valid_reg;
    assign sorted_bits    = sorted_bits_reg;
    assign original_index = original_index_reg;
    assign last_result    = last_result_reg;
    assign nothing_ready  = nothing_ready_reg;
    assign overflowed     = overflowed_reg;

    // memories, written and read in clocked blocks
    always_ff @(posedge clk)
    begin
        if (we && !wbank)
        begin
            val_mem0[waddr] <= wval;
            idx_mem0[waddr] <= widx;
        end
        if (we && wbank)
        begin
            val_mem1[waddr] <= wval;
            idx_mem1[waddr] <= widx;
        end
        if (rd_en)
        begin
            rv0_reg <= val_mem0[raddr];
            ri0_reg <= idx_mem0[raddr];
            rv1_reg <= val_mem1[raddr];
            ri1_reg <= idx_mem1[raddr];
        end
    end

    // control combinational
    always_comb
    begin
        q_pop = 1'b0;
        we    = 1'b0;
        wbank = cur_reg;
        waddr = loaded_reg[AW-1:0];
        wval  = q_cmd.value;
        widx  = IDXW'(loaded_reg);
        rd_en = 1'b0;
        raddr = p_reg[AW-1:0];
        case (state_reg)
            S_IDLE:
            begin
                if (q_valid && q_cmd.op == OP_LOAD && !done_reg &&
                    loaded_reg < CW'(MAX_ITEMS))
                    we = 1'b1;
                if (q_valid && !(q_cmd.op == OP_FETCH && out_valid_reg))
                    q_pop = 1'b1;
            end
            S_RDP:
            begin
                rd_en = 1'b1;
                raddr = p_reg[AW-1:0];
            end
            S_RDQ:
            begin
                rd_en = 1'b1;
                raddr = q_reg[AW-1:0];
            end
            S_CMP:
            begin
                we    = 1'b1;
                wbank = ~cur_reg;
                waddr = k_reg[AW-1:0];
                wval  = take_run ? pv_reg : qv_reg;
                widx  = take_run ? pi_reg : qi_reg;
            end
            S_FRD:
            begin
                rd_en = 1'b1;
                raddr = rdp_reg[AW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            loaded_reg    <= '0;
            merged_reg    <= '0;
            cur_reg       <= 1'b0;
            rdp_reg       <= '0;
            ovf_reg       <= 1'b0;
            done_reg      <= 1'b0;
            fin_reg       <= 1'b0;
            p_reg         <= '0;
            q_reg         <= '0;
            k_reg         <= '0;
            rb_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // taken item leaves, unless the fetch output state replaces it
            if (out_valid_reg && out_ready && state_reg != S_FOUT)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (q_pop && q_cmd.op == OP_LOAD && !done_reg)
                    begin
                        if (loaded_reg < CW'(MAX_ITEMS))
                            loaded_reg <= loaded_reg + 1'b1;
                        else
                            ovf_reg <= 1'b1;
                        fin_reg <= q_cmd.fin;
                        if (q_cmd.close)
                        begin
                            p_reg     <= '0;
                            q_reg     <= merged_reg;
                            k_reg     <= '0;
                            rb_reg    <= cur_reg;
                            state_reg <= S_RDP;
                        end
                    end
                    else if (q_pop && q_cmd.op == OP_FETCH)
                    begin
                        if (done_reg && rdp_reg < merged_reg)
                        begin
                            rb_reg    <= cur_reg;
                            state_reg <= S_FRD;
                        end
                        else
                        begin
                            sorted_bits_reg    <= '0;
                            original_index_reg <= '0;
                            last_result_reg    <= 1'b0;
                            nothing_ready_reg  <= 1'b1;
                            overflowed_reg     <= ovf_reg;
                            out_valid_reg      <= 1'b1;
                        end
                    end
                end
                S_RDP:
                    state_reg <= S_RDQ;
                S_RDQ:
                begin
                    pv_reg    <= rv;
                    pi_reg    <= ri;
                    state_reg <= S_WAIT;
                end
                S_WAIT:
                begin
                    qv_reg <= rv;
                    qi_reg <= ri;
                    if (!p_left && !q_left)
                    begin
                        // block fully merged, swap banks
                        cur_reg    <= ~cur_reg;
                        merged_reg <= loaded_reg;
                        if (fin_reg)
                        begin
                            done_reg <= 1'b1;
                            rdp_reg  <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                    else
                        state_reg <= S_CMP;
                end
                S_CMP:
                begin
                    k_reg <= k_reg + 1'b1;
                    if (take_run)
                        p_reg <= p_reg + 1'b1;
                    else
                        q_reg <= q_reg + 1'b1;
                    state_reg <= S_RDP;
                end
                S_FRD:
                    state_reg <= S_FOUT;
                S_FOUT:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        sorted_bits_reg    <= rv;
                        original_index_reg <= ri;
                        last_result_reg    <= (rdp_reg + 1'b1 == merged_reg);
                        nothing_ready_reg  <= 1'b0;
                        overflowed_reg     <= ovf_reg;
                        out_valid_reg      <= 1'b1;
                        rdp_reg            <= rdp_reg + 1'b1;
                        state_reg          <= S_IDLE;
                    end
                end
                default:
                    state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

[sv/sorted_block_merge_with_index_unit.sv]
// ----------------------------------------------------------------------------
// sorted_block_merge_with_index_unit: stable merge of presorted blocks
// loads tagged doubles, merges each closed block, returns sorted items
// ----------------------------------------------------------------------------
// channel  dir  handshake         payload
// s_axis   in   tvalid / tready   tdata: value_bits; tlast: block_end;
//                                 tuser: command, final_item
// m_axis   out  tvalid / tready   tdata: sorted_bits, original_index;
//                                 tlast: last_result; tuser: nothing_ready, overflowed
// a load is taken in the back end's idle state; a block close merges the whole run,
// reading run and block heads in turn on the buffers' single read port, writing the smaller;
// a fetch reads one item; a four-entry queue decouples input from the engine
// no clearing pass after reset; the output register holds while m_axis stalls
// ----------------------------------------------------------------------------
module sorted_block_merge_with_index_unit
    import sbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [63:0] s_axis_tdata,   // value_bits
    input  logic        s_axis_tlast,   // block_end
    input  logic [1:0]  s_axis_tuser,   // command, final_item
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // sorted_bits, original_index, zero fill
    output logic        m_axis_tlast,   // last_result
    output logic [1:0]  m_axis_tuser    // nothing_ready, overflowed
);

    logic            q_valid;
    logic            q_pop;
    cmd_t            q_cmd;
    logic [63:0]     sorted_bits;
    logic [IDXW-1:0] original_index;
    logic            last_result;
    logic            nothing_ready;
    logic            overflowed;

    sbm_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .command    (s_axis_tuser[0]),
        .value_bits (s_axis_tdata),
        .block_end  (s_axis_tlast),
        .final_item (s_axis_tuser[1]),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_cmd      (q_cmd)
    );

    sbm_back u_back
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_valid        (q_valid),
        .q_pop          (q_pop),
        .q_cmd          (q_cmd),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .sorted_bits    (sorted_bits),
        .original_index (original_index),
        .last_result    (last_result),
        .nothing_ready  (nothing_ready),
        .overflowed     (overflowed)
    );

    assign m_axis_tdata = {6'd0, original_index, sorted_bits};
    assign m_axis_tlast = last_result;
    assign m_axis_tuser = {overflowed, nothing_ready};

endmodule
